/* hw/rtl/hrbd_pkg.sv */
// ----------------------------------------------------------------------------
// hrbd_pkg
// Shared types and constants of the reply body deframer.
// ----------------------------------------------------------------------------
`default_nettype none
package hrbd_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_STATUS   = 3'd1,
    ERR_NO_FRAME = 3'd2,
    ERR_HEX      = 3'd3,
    ERR_EMPTY    = 3'd4,
    ERR_CRLF     = 3'd5,
    ERR_OVERFLOW = 3'd6
  } err_e;

  localparam int unsigned LenKeyN = 16;
  localparam int unsigned ChkKeyN = 28;

  // key characters
  function automatic logic [7:0] len_key(input logic [4:0] pos);
    logic [7:0] ch;
    unique case (pos)
      5'd0: ch = "C";  5'd1: ch = "o";  5'd2: ch = "n";  5'd3: ch = "t";
      5'd4: ch = "e";  5'd5: ch = "n";  5'd6: ch = "t";  5'd7: ch = "-";
      5'd8: ch = "L";  5'd9: ch = "e";  5'd10: ch = "n"; 5'd11: ch = "g";
      5'd12: ch = "t"; 5'd13: ch = "h"; 5'd14: ch = ":"; 5'd15: ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] chk_key(input logic [4:0] pos);
    logic [7:0] ch;
    unique case (pos)
      5'd0: ch = "T";  5'd1: ch = "r";  5'd2: ch = "a";  5'd3: ch = "n";
      5'd4: ch = "s";  5'd5: ch = "f";  5'd6: ch = "e";  5'd7: ch = "r";
      5'd8: ch = "-";  5'd9: ch = "E";  5'd10: ch = "n"; 5'd11: ch = "c";
      5'd12: ch = "o"; 5'd13: ch = "d"; 5'd14: ch = "i"; 5'd15: ch = "n";
      5'd16: ch = "g"; 5'd17: ch = ":"; 5'd18: ch = " "; 5'd19: ch = "c";
      5'd20: ch = "h"; 5'd21: ch = "u"; 5'd22: ch = "n"; 5'd23: ch = "k";
      5'd24: ch = "e"; 5'd25: ch = "d"; 5'd26: ch = 8'h0d; 5'd27: ch = 8'h0a;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // classified item passed from front to back
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       reply_start;
    logic       is_digit;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_space;
    logic       is_cr;
    logic       is_lf;
  } cls_t;

endpackage
`default_nettype wire

/* hw/rtl/hrbd_front.sv */
// ----------------------------------------------------------------------------
// hrbd_front
// Accepts bytes and classifies them into a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module hrbd_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [7:0]         rx_byte_i,
  input  wire                reply_start_i,
  output logic               q_valid_o,
  output hrbd_pkg::cls_t     q_item_o,
  input  wire                q_pop_i
);
  import hrbd_pkg::*;

  cls_t       mem_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  cls_t       cls;
  logic       push;

  // byte classification
  always_comb begin
    cls.rx_byte     = rx_byte_i;
    cls.reply_start = reply_start_i;
    cls.is_digit    = (rx_byte_i >= "0") && (rx_byte_i <= "9");
    cls.is_space    = rx_byte_i == " ";
    cls.is_cr       = rx_byte_i == 8'h0d;
    cls.is_lf       = rx_byte_i == 8'h0a;
    cls.is_hex      = 1'b1;
    cls.hex_val     = '0;
    if (cls.is_digit) begin
      cls.hex_val = rx_byte_i[3:0];
    end else if ((rx_byte_i >= "A" && rx_byte_i <= "F") ||
                 (rx_byte_i >= "a" && rx_byte_i <= "f")) begin
      cls.hex_val = rx_byte_i[3:0] + 4'd9;
    end else begin
      cls.is_hex = 1'b0;
    end
  end

  assign in_stall  = cnt_q == 2'd2;
  assign push      = in_valid && !in_stall;
  assign q_valid_o = cnt_q != 2'd0;
  assign q_item_o  = mem_q[rd_q];

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end
endmodule
`default_nettype wire

/* hw/rtl/hrbd_back.sv */
// ----------------------------------------------------------------------------
// hrbd_back
// Parses classified bytes and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module hrbd_back #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_valid_i,
  input  hrbd_pkg::cls_t     q_item_i,
  output logic               q_pop_o,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [1:0]         out_kind_o,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic [9:0]         status_code_o,
  output logic [2:0]         error_code_o
);
  import hrbd_pkg::*;

  typedef enum logic [7:0] {
    PH_HEAD = 8'b00000001, PH_BODY = 8'b00000010, PH_SIZE = 8'b00000100,
    PH_DATA = 8'b00001000, PH_DCR  = 8'b00010000, PH_DLF  = 8'b00100000,
    PH_DONE = 8'b01000000, PH_ERR  = 8'b10000000
  } phase_e;

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;
  localparam logic [LENGTH_BITS-1:0] LenLim = LenMax / 10;
  localparam logic [3:0] LenLimDig = 4'(LenMax % 10);

  phase_e                 ph_q, ph_d;
  logic [1:0]             crlf_q, crlf_d;
  logic [4:0]             lk_q, lk_d, ck_q, ck_d;
  logic [1:0]             sp_q, sp_d;
  logic [9:0]             st_q, st_d;
  logic                   sl_q, sl_d, sc_q, sc_d;
  logic [LENGTH_BITS-1:0] len_q, len_d, rem_q, rem_d, hex_q, hex_d;
  logic [3:0]             slc_q, slc_d;

  logic       ov_q, ov_d;
  logic [1:0] ok_q, ok_d;
  logic [7:0] ob_q, ob_d;
  logic       ol_q, ol_d;
  logic [2:0] oe_q, oe_d;
  logic       emit;

  logic [7:0]  c;
  logic [3:0]  d;
  logic [13:0] sv;
  logic [LENGTH_BITS-1:0] rem_m1;
  logic        fail;
  logic [2:0]  ferr;

  assign q_pop_o = q_valid_i && (!ov_q || !out_stall);

  always_comb begin
    c = q_item_i.rx_byte;
    d = c[3:0];
    ph_d = ph_q; crlf_d = crlf_q; lk_d = lk_q; ck_d = ck_q; sp_d = sp_q;
    st_d = st_q; sl_d = sl_q; sc_d = sc_q; len_d = len_q; rem_d = rem_q;
    hex_d = hex_q; slc_d = slc_q;
    emit = 1'b0; ok_d = KIND_BYTE; ob_d = '0; ol_d = 1'b0; oe_d = ERR_NONE;
    fail = 1'b0; ferr = ERR_NONE;
    sv = '0;
    // start of a new reply clears the parser
    if (q_item_i.reply_start) begin
      ph_d = PH_HEAD; crlf_d = '0; lk_d = '0; ck_d = '0; sp_d = '0; st_d = '0;
      sl_d = 1'b0; sc_d = 1'b0; len_d = '0; rem_d = '0; hex_d = '0; slc_d = '0;
    end
    rem_m1 = rem_d - 1'b1;
    unique case (ph_d)
      PH_HEAD: begin
        sv = 14'(st_d) * 14'd10 + 14'(d);
        // status code field
        if (sp_d == 2'd0) begin
          if (q_item_i.is_space) sp_d = 2'd1;
        end else if (sp_d == 2'd1) begin
          if (q_item_i.is_space) sp_d = 2'd2;
          else if (q_item_i.is_digit) begin
            if (sv > 14'd999) begin fail = 1'b1; ferr = ERR_STATUS; end
            else st_d = sv[9:0];
          end else begin fail = 1'b1; ferr = ERR_STATUS; end
        end
        if (!fail) begin
          // length key and digits
          if (lk_d >= 5'(LenKeyN)) begin
            if (q_item_i.is_digit) begin
              if (len_d > LenLim || (len_d == LenLim && d > LenLimDig)) begin
                fail = 1'b1; ferr = ERR_OVERFLOW;
              end else begin
                len_d = LENGTH_BITS'(len_d * 10) + LENGTH_BITS'(d);
              end
            end else lk_d = '0;
          end else if (!sl_d) begin
            lk_d = (len_key(lk_d) == c) ? lk_d + 5'd1 :
                   ((c == "C") ? 5'd1 : 5'd0);
            if (lk_d >= 5'(LenKeyN)) begin sl_d = 1'b1; len_d = '0; end
          end
        end
        if (!fail) begin
          // chunked key
          if (!sc_d) begin
            ck_d = (chk_key(ck_d) == c) ? ck_d + 5'd1 :
                   ((c == "T") ? 5'd1 : 5'd0);
            if (ck_d >= 5'(ChkKeyN)) begin sc_d = 1'b1; ck_d = '0; end
          end
          // header end detection
          if (q_item_i.is_cr) crlf_d = (crlf_d == 2'd2) ? 2'd3 : 2'd1;
          else if (q_item_i.is_lf && crlf_d == 2'd1) crlf_d = 2'd2;
          else if (!(q_item_i.is_lf && crlf_d == 2'd3)) crlf_d = 2'd0;
          else begin
            crlf_d = '0; lk_d = '0;
            if (sp_d < 2'd2) begin fail = 1'b1; ferr = ERR_STATUS; end
            else if (sl_d) begin
              if (len_d == '0) begin ph_d = PH_DONE; emit = 1'b1; ok_d = KIND_DONE; end
              else begin rem_d = len_d; ph_d = PH_BODY; end
            end else if (sc_d) begin
              hex_d = '0; slc_d = '0; ph_d = PH_SIZE;
            end else begin fail = 1'b1; ferr = ERR_NO_FRAME; end
          end
        end
      end
      PH_BODY: begin
        rem_d = rem_m1; emit = 1'b1; ob_d = c;
        if (rem_m1 == '0) begin ph_d = PH_DONE; ol_d = 1'b1; end
      end
      PH_SIZE: begin
        if (q_item_i.is_cr) begin
        end else if (q_item_i.is_lf) begin
          if (slc_d == '0) begin fail = 1'b1; ferr = ERR_EMPTY; end
          else if (hex_d == '0) begin ph_d = PH_DONE; emit = 1'b1; ok_d = KIND_DONE; end
          else begin rem_d = hex_d; ph_d = PH_DATA; end
        end else if (!q_item_i.is_hex) begin fail = 1'b1; ferr = ERR_HEX; end
        else if (hex_d[LENGTH_BITS-1 -: 4] != 4'd0) begin
          fail = 1'b1; ferr = ERR_OVERFLOW;
        end else begin
          hex_d = {hex_d[LENGTH_BITS-5:0], q_item_i.hex_val};
          if (slc_d != 4'd15) slc_d = slc_d + 4'd1;
        end
      end
      PH_DATA: begin
        rem_d = rem_m1; emit = 1'b1; ob_d = c;
        if (rem_m1 == '0) ph_d = PH_DCR;
      end
      PH_DCR: begin
        if (!q_item_i.is_cr) begin fail = 1'b1; ferr = ERR_CRLF; end
        else ph_d = PH_DLF;
      end
      PH_DLF: begin
        if (!q_item_i.is_lf) begin fail = 1'b1; ferr = ERR_CRLF; end
        else begin hex_d = '0; slc_d = '0; ph_d = PH_SIZE; end
      end
      default: begin
      end
    endcase
    // error result
    if (fail) begin
      ph_d = PH_ERR; emit = 1'b1; ok_d = KIND_ERROR; oe_d = ferr;
      ob_d = '0; ol_d = 1'b0;
    end
    ov_d = ov_q && out_stall;
    if (q_pop_o && emit) ov_d = 1'b1;
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_HEAD; crlf_q <= '0; lk_q <= '0; ck_q <= '0; sp_q <= '0;
      st_q <= '0; sl_q <= 1'b0; sc_q <= 1'b0; len_q <= '0; rem_q <= '0;
      hex_q <= '0; slc_q <= '0; ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      if (q_pop_o) begin
        ph_q <= ph_d; crlf_q <= crlf_d; lk_q <= lk_d; ck_q <= ck_d; sp_q <= sp_d;
        st_q <= st_d; sl_q <= sl_d; sc_q <= sc_d; len_q <= len_d; rem_q <= rem_d;
        hex_q <= hex_d; slc_q <= slc_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      ok_q <= ok_d; ob_q <= ob_d; ol_q <= ol_d; oe_q <= oe_d;
      status_code_o <= st_d;
    end
  end

  assign out_valid    = ov_q;
  assign out_kind_o   = ok_q;
  assign out_byte_o   = ob_q;
  assign out_last_o   = ol_q;
  assign error_code_o = oe_q;
endmodule
`default_nettype wire

/* hw/rtl/http_reply_body_deframer_top.sv */
// ----------------------------------------------------------------------------
// http_reply_body_deframer_top
// HTTP/1.1 reply deframer: length and chunked body extraction.
// ----------------------------------------------------------------------------
// Throughput one byte per cycle while the receiver does not stall the output.
// An accepted byte passes through the queue, then the result register, before its result is valid.
// A two-entry queue separates the classifier and parser.
// Asynchronous active-low reset clears queue, parser state and output valid.
`default_nettype none
module http_reply_body_deframer_top #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  rx_byte_i,
  input  wire         reply_start_i,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [9:0]  status_code_o,
  output logic [2:0]  error_code_o
);
  import hrbd_pkg::*;

  cls_t q_item;
  logic q_valid, q_pop;

  hrbd_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .rx_byte_i, .reply_start_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  hrbd_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid, .out_stall, .out_kind_o, .out_byte_o, .out_last_o,
    .status_code_o, .error_code_o
  );
endmodule
`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the reply body deframer: directed replies from a
// table, directed cases, a receiver hold-off, then random length and chunked
// replies plus noise, all checked item by item against a behavioral predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrbd_pkg::*;

  localparam int unsigned LB = 32;
  localparam int unsigned WATCHDOG = 20000;

  typedef enum logic [2:0] {
    PH_HEAD, PH_BODY, PH_SIZE, PH_DATA, PH_DCR, PH_DLF, PH_DONE, PH_ERR
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
    logic [9:0] status;
    err_e       err;
  } reply_res_t;

  typedef struct {
    logic [7:0] b;
    logic       st;
    logic       chk;
    reply_res_t res;
  } dir_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [7:0] rx_byte;
  logic reply_start;
  logic [1:0] o_kind;
  logic [7:0] o_byte;
  logic o_last;
  logic [9:0] o_status;
  logic [2:0] o_err;

  http_reply_body_deframer_top #(.LENGTH_BITS(LB)) i_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .rx_byte_i(rx_byte), .reply_start_i(reply_start), .out_valid(out_valid),
    .out_stall(out_stall), .out_kind_o(o_kind), .out_byte_o(o_byte),
    .out_last_o(o_last), .status_code_o(o_status), .error_code_o(o_err)
  );

  // predictor state
  phase_e     ph;
  logic [1:0] crlf_m, spaces;
  logic [4:0] len_m, chk_m;
  logic [9:0] status_acc;
  logic       got_len, got_chk;
  logic [63:0] len_acc, remain, hex_acc;
  logic [3:0] hex_cnt;

  reply_res_t expected_q[$];
  int unsigned n_mismatch, n_results, n_errors, n_done, n_accepted;
  int unsigned n_table_bad;
  int unsigned idle_cycles;
  logic hold_off;

  // prediction of the most recently accepted byte
  bit         last_hit;
  reply_res_t last_pred;

  function automatic logic [63:0] len_max();
    return (64'd1 << LB) - 64'd1;
  endfunction

  function automatic reply_res_t mk(kind_e k, logic [7:0] d, logic l, err_e e);
    reply_res_t r;
    r.kind = k; r.data = d; r.last = l; r.status = status_acc; r.err = e;
    return r;
  endfunction

  task automatic clear_parser();
    ph = PH_HEAD; crlf_m = 0; spaces = 0; len_m = 0; chk_m = 0;
    status_acc = 0; got_len = 0; got_chk = 0; len_acc = 0; remain = 0;
    hex_acc = 0; hex_cnt = 0;
  endtask

  task automatic raise(err_e e, output bit hit, output reply_res_t r);
    ph = PH_ERR; r = mk(KIND_ERROR, 8'd0, 1'b0, e); hit = 1;
  endtask

  // header byte: status, key matches, blank line detection
  task automatic header_step(logic [7:0] c, output bit hit, output reply_res_t r);
    int unsigned v;
    logic [63:0] d;
    logic [7:0] kc;
    hit = 0;
    if (spaces == 0) begin
      if (c == " ") spaces = 1;
    end else if (spaces == 1) begin
      if (c == " ") spaces = 2;
      else if (c >= "0" && c <= "9") begin
        v = status_acc * 10 + (c - "0");
        if (v > 999) begin raise(ERR_STATUS, hit, r); return; end
        status_acc = v[9:0];
      end else begin
        raise(ERR_STATUS, hit, r); return;
      end
    end
    if (len_m >= LenKeyN) begin
      if (c >= "0" && c <= "9") begin
        d = c - "0";
        if (len_acc > (len_max() - d) / 10) begin raise(ERR_OVERFLOW, hit, r); return; end
        len_acc = len_acc * 10 + d;
      end else len_m = 0;
    end else if (!got_len) begin
      kc = len_key(len_m);
      len_m = (kc == c) ? len_m + 5'd1 : ((c == "C") ? 5'd1 : 5'd0);
      if (len_m >= LenKeyN) begin got_len = 1; len_acc = 0; end
    end
    if (!got_chk) begin
      kc = chk_key(chk_m);
      chk_m = (kc == c) ? chk_m + 5'd1 : ((c == "T") ? 5'd1 : 5'd0);
      if (chk_m >= ChkKeyN) begin got_chk = 1; chk_m = 0; end
    end
    if (c == 8'h0d) begin crlf_m = (crlf_m == 2) ? 2'd3 : 2'd1; return; end
    if (c == 8'h0a && crlf_m == 1) begin crlf_m = 2; return; end
    if (!(c == 8'h0a && crlf_m == 3)) begin crlf_m = 0; return; end
    crlf_m = 0; len_m = 0;
    if (spaces < 2) begin raise(ERR_STATUS, hit, r); return; end
    if (got_len) begin
      if (len_acc == 0) begin
        ph = PH_DONE; r = mk(KIND_DONE, 0, 0, ERR_NONE); hit = 1; return;
      end
      remain = len_acc; ph = PH_BODY; return;
    end
    if (got_chk) begin hex_acc = 0; hex_cnt = 0; ph = PH_SIZE; return; end
    raise(ERR_NO_FRAME, hit, r);
  endtask

  // one accepted byte through the predictor
  task automatic predict_deframe(logic [7:0] c, logic st, output bit hit,
                                 output reply_res_t r);
    int h;
    hit = 0;
    if (st) clear_parser();
    case (ph)
      PH_HEAD: header_step(c, hit, r);
      PH_BODY: begin
        remain = remain - 1; hit = 1;
        if (remain == 0) begin ph = PH_DONE; r = mk(KIND_BYTE, c, 1, ERR_NONE); end
        else r = mk(KIND_BYTE, c, 0, ERR_NONE);
      end
      PH_SIZE: begin
        if (c == 8'h0d) return;
        if (c == 8'h0a) begin
          if (hex_cnt == 0) begin raise(ERR_EMPTY, hit, r); return; end
          if (hex_acc == 0) begin
            ph = PH_DONE; r = mk(KIND_DONE, 0, 0, ERR_NONE); hit = 1; return;
          end
          remain = hex_acc; ph = PH_DATA; return;
        end
        if (c >= "0" && c <= "9") h = c - "0";
        else if (c >= "A" && c <= "F") h = c - "A" + 10;
        else if (c >= "a" && c <= "f") h = c - "a" + 10;
        else h = -1;
        if (h < 0) begin raise(ERR_HEX, hit, r); return; end
        if ((hex_acc >> (LB - 4)) != 0) begin raise(ERR_OVERFLOW, hit, r); return; end
        hex_acc = ((hex_acc << 4) | h) & len_max();
        if (hex_cnt < 15) hex_cnt++;
      end
      PH_DATA: begin
        remain = remain - 1;
        if (remain == 0) ph = PH_DCR;
        r = mk(KIND_BYTE, c, 0, ERR_NONE); hit = 1;
      end
      PH_DCR: begin
        if (c != 8'h0d) raise(ERR_CRLF, hit, r); else ph = PH_DLF;
      end
      PH_DLF: begin
        if (c != 8'h0a) raise(ERR_CRLF, hit, r);
        else begin hex_acc = 0; hex_cnt = 0; ph = PH_SIZE; end
      end
      default: ;
    endcase
  endtask

  // clock and reset
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int unsigned mode;
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1;
      else begin
        mode = (n_accepted / 97) % 3;
        if (mode == 0) out_stall <= 0;
        else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    reply_res_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        n_results <= n_results + 1;
        if (expected_q.size() == 0) begin
          n_mismatch <= n_mismatch + 1;
          if (n_mismatch < 10) $display("unexpected result kind=%0d", o_kind);
        end else begin
          e = expected_q.pop_front();
          if (e.kind == KIND_ERROR) n_errors <= n_errors + 1;
          if (e.kind == KIND_DONE) n_done <= n_done + 1;
          if (o_kind !== e.kind || o_byte !== e.data || o_last !== e.last ||
              o_status !== e.status || o_err !== e.err) begin
            n_mismatch <= n_mismatch + 1;
            if (n_mismatch < 10)
              $display("mismatch: exp k%0d b%02h l%0d s%0d e%0d got k%0d b%02h l%0d s%0d e%0d",
                       e.kind, e.data, e.last, e.status, e.err,
                       o_kind, o_byte, o_last, o_status, o_err);
          end
        end
      end
      if (idle_cycles > WATCHDOG) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // one byte through the handshake, predicted on acceptance
  task automatic send_byte(logic [7:0] c, logic st);
    bit hit;
    reply_res_t r;
    in_valid <= 1; rx_byte <= c; reply_start <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_accepted++;
    predict_deframe(c, st, hit, r);
    last_hit = hit; last_pred = r;
    if (hit) expected_q.push_back(r);
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_str(string s, logic first);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], first && i == 0);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic string hex_str(int unsigned v);
    return $sformatf("%h", v);
  endfunction

  // random reply with either framing, occasionally broken
  task automatic random_reply();
    string hdr;
    int unsigned n, k, code;
    bit chunked;
    chunked = $urandom_range(0, 1);
    code = $urandom_range(100, 599);
    hdr = $sformatf("HTTP/1.1 %0d OK\r\nServer: x\r\n", code);
    if ($urandom_range(0, 9) == 0) hdr = $sformatf("HTTP/1.1 %0dz\r\n", code);
    n = $urandom_range(0, 12);
    if (chunked) hdr = {hdr, "Transfer-Encoding: chunked\r\n\r\n"};
    else hdr = {hdr, $sformatf("Content-Length: %0d\r\n\r\n", n)};
    send_str(hdr, 1);
    if (!chunked) begin
      for (int i = 0; i < n; i++) send_byte(8'($urandom), 0);
    end else begin
      k = $urandom_range(1, 3);
      for (int j = 0; j < k; j++) begin
        n = $urandom_range(1, 10);
        send_str({($urandom_range(0, 1) ? hex_str(n) : $sformatf("%0X", n)), "\r\n"}, 0);
        for (int i = 0; i < n; i++) send_byte(8'($urandom), 0);
        if ($urandom_range(0, 11) == 0) send_byte(8'($urandom), 0);
        send_str("\r\n", 0);
      end
      if ($urandom_range(0, 11) == 0) send_byte(8'($urandom), 0);
      send_str("0\r\n\r\n", 0);
    end
    for (int i = $urandom_range(0, 2); i > 0; i--) send_byte(8'($urandom), 0);
  endtask

  dir_row_t dir_rows[$];
  task automatic add_row(logic [7:0] b, logic st, logic chk, reply_res_t r);
    dir_row_t d;
    d.b = b; d.st = st; d.chk = chk; d.res = r;
    dir_rows.push_back(d);
  endtask

  initial begin
    string s;
    reply_res_t none, r_ok, r_e1;
    in_valid = 0; rx_byte = 0; reply_start = 0; hold_off = 0;
    n_mismatch = 0; n_results = 0; n_errors = 0; n_done = 0; n_accepted = 0;
    n_table_bad = 0; last_hit = 0; last_pred = '0;
    idle_cycles = 0;
    clear_parser();
    none = '0;
    // table: short zero-length reply, then a bad status line
    s = "H 204 \r\n";
    for (int i = 0; i < s.len(); i++) add_row(s[i], i == 0, 0, none);
    s = "Content-Length: 0\r\n\r";
    for (int i = 0; i < s.len(); i++) add_row(s[i], 0, 0, none);
    r_ok = '{KIND_DONE, 8'd0, 1'b0, 10'd204, ERR_NONE};
    add_row(8'h0a, 0, 1, r_ok);
    add_row(8'hff, 0, 0, none);
    r_e1 = '{KIND_ERROR, 8'd0, 1'b0, 10'd0, ERR_STATUS};
    add_row(8'h20, 1, 0, none);
    add_row(8'h00, 0, 1, r_e1);
    @(posedge rst_n);
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].st);
      if (dir_rows[i].chk && (!last_hit || last_pred !== dir_rows[i].res)) begin
        n_table_bad++;
        $display("table row %0d: predictor disagrees with typed result", i);
      end
    end
    drain();
    // directed special cases checked against predictor
    send_str("HTTP/1.1 1000 X\r\n\r\n", 1);
    send_str("HTTP/1.1 200 OK\r\nA: b\r\n\r\n", 1);
    send_str("HTTP/1.1 200 OK\r\nContent-Length: 99999999999\r\n\r\n", 1);
    send_str("HTTP/1.1 200 OK\r\nContent-Length: 4294967295\r\n\r\nab", 1);
    send_str("X 200 Transfer-Encoding: chunked\r\n\r\nfFfFfFfFf\r\n", 1);
    send_str("X 200 Transfer-Encoding: chunked\r\n\r\n\r\n", 1);
    send_str("X 200 Transfer-Encoding: chunked\r\n\r\n3;x\r\n", 1);
    send_str("X 200 Transfer-Encoding: chunked\r\n\r\n2\r\nab\rX", 1);
    send_str("X 999 Transfer-Encoding: chunked\r\nContent-Length: 2\r\n\r\n", 1);
    send_byte(8'h00, 0); send_byte(8'hff, 0);
    send_str("X 1 Transfer-Encoding: chunked\r\n\r\n1\r\n", 1);
    send_byte(8'h80, 0);
    send_str("\r\n0\r\n\r\n", 0);
    drain();
    // long receiver hold-off while sender keeps offering body bytes
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      begin
        send_str("HTTP/1.1 200 OK\r\nContent-Length: 40\r\n\r\n", 1);
        for (int i = 0; i < 40; i++) send_byte(8'($urandom), 0);
        in_valid <= 0;
      end
    join
    drain();
    // random replies, mostly well formed
    while (n_accepted < 600) begin
      if ($urandom_range(0, 15) == 0) send_byte(8'($urandom), $urandom_range(0, 1));
      else random_reply();
      if ($urandom_range(0, 30) == 0) drain();
    end
    drain();
    $display("covered %0d bytes, %0d results, %0d completions, %0d errors",
             n_accepted, n_results, n_done, n_errors);
    if (n_mismatch == 0 && n_table_bad == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
